/* rtl/clbe_pkg.sv */
// Shared types, codes and helper functions for the load and branch execute core.
package clbe_pkg;

  // Word kinds on the input channel
  localparam logic OPER_INSTR = 1'b0;
  localparam logic OPER_REPLY = 1'b1;

  // Instruction classes found by the front decoder
  localparam logic [2:0] CL_LDRR  = 3'd0;
  localparam logic [2:0] CL_HALT  = 3'd1;
  localparam logic [2:0] CL_LDRN  = 3'd2;
  localparam logic [2:0] CL_PUSH  = 3'd3;
  localparam logic [2:0] CL_POP   = 3'd4;
  localparam logic [2:0] CL_RST   = 3'd5;
  localparam logic [2:0] CL_OTHER = 3'd6;

  // Opcodes that the decoder singles out
  localparam logic [7:0] OP_HALT    = 8'h76;
  localparam logic [7:0] OP_LD_HL_N = 8'h36;
  localparam logic [7:0] OP_PUSH_AF = 8'hF5;
  localparam logic [7:0] OP_POP_AF  = 8'hF1;

  // Register file slots
  localparam logic [2:0] IX_B = 3'd0;
  localparam logic [2:0] IX_C = 3'd1;
  localparam logic [2:0] IX_D = 3'd2;
  localparam logic [2:0] IX_E = 3'd3;
  localparam logic [2:0] IX_H = 3'd4;
  localparam logic [2:0] IX_L = 3'd5;
  localparam logic [2:0] IX_A = 3'd6;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  // Queued word between front and back
  typedef struct packed {
    logic        operation;
    logic [2:0]  iclass;
    logic [7:0]  opcode;
    logic [15:0] immediate;
    logic [15:0] read_data;
    logic [4:0]  pending_irq;
  } item_t;

  // Result word
  typedef struct packed {
    logic [15:0] mem_addr;
    logic        mem_write;
    logic        mem_read;
    logic        mem_wide;
    logic [15:0] write_data;
    logic [15:0] next_pc;
    logic [4:0]  cycles;
    logic        halted;
    logic        stopped;
    logic        halt_skip;
    logic        ime;
  } res_t;

  // Front to back link
  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

  // Map a 3-bit register code to a file slot; (HL) and A both land on A
  function automatic logic [2:0] rix(input logic [2:0] code);
    rix = (code >= 3'd6) ? IX_A : code;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    sext8 = {{8{b[7]}}, b};
  endfunction

endpackage

/* rtl/clbe_front.sv */
// Front part: classify incoming words and hold them in a two-entry queue.
module clbe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_operation,
  input  logic [7:0]       in_opcode,
  input  logic [15:0]      in_immediate,
  input  logic [15:0]      in_read_data,
  input  logic [4:0]       in_pending_irq,
  output clbe_pkg::link_t  head,
  input  logic             take
);

  clbe_pkg::item_t mem_r [2];
  logic            wptr_r, wptr_nxt;
  logic            rptr_r, rptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0]      iclass;
  logic            do_push, do_pop;
  clbe_pkg::item_t word;

  // Classify the opcode
  always_comb begin
    if (in_opcode[7:6] == 2'b01) begin
      iclass = (in_opcode == clbe_pkg::OP_HALT) ? clbe_pkg::CL_HALT : clbe_pkg::CL_LDRR;
    end else if ((in_opcode & 8'hC7) == 8'h06 && in_opcode != clbe_pkg::OP_LD_HL_N) begin
      iclass = clbe_pkg::CL_LDRN;
    end else if ((in_opcode & 8'hCF) == 8'hC5) begin
      iclass = clbe_pkg::CL_PUSH;
    end else if ((in_opcode & 8'hCF) == 8'hC1) begin
      iclass = clbe_pkg::CL_POP;
    end else if ((in_opcode & 8'hC7) == 8'hC7) begin
      iclass = clbe_pkg::CL_RST;
    end else begin
      iclass = clbe_pkg::CL_OTHER;
    end
  end

  assign word = '{operation: in_operation, iclass: iclass, opcode: in_opcode,
                  immediate: in_immediate, read_data: in_read_data,
                  pending_irq: in_pending_irq};

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = take && (cnt_r != 2'd0);

  assign wptr_nxt = do_push ? ~wptr_r : wptr_r;
  assign rptr_nxt = do_pop ? ~rptr_r : rptr_r;
  assign cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  // Store accepted words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= word;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rptr_r];

endmodule

/* rtl/clbe_back.sv */
// Back part: architectural state, instruction execution and the result queue.
module clbe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  clbe_pkg::link_t  head,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output clbe_pkg::res_t   res
);

  logic [7:0]  gp_r [7];
  logic [7:0]  gp_nxt [7];
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        ime_r, ime_nxt;
  logic        halt_r, halt_nxt;
  logic        hbug_r, hbug_nxt;
  logic        stop_r, stop_nxt;
  logic [7:0]  wop_r, wop_nxt;
  logic        wval_r, wval_nxt;

  clbe_pkg::res_t oq_r [2];
  logic           owp_r, orp_r;
  logic [1:0]     ocnt_r;
  logic           opop;

  clbe_pkg::item_t it;
  clbe_pkg::res_t  r;
  logic [7:0]  op, n8, b;
  logic [15:0] hl, p1, p2, p3, spm2, e16, dat, hl_sum;
  logic [2:0]  phi;
  logic        cond, zf, cf;
  logic [4:0]  hsum;
  logic [8:0]  csum;

  assign it   = head.item;
  assign take = head.valid && (ocnt_r != 2'd2);
  assign op   = it.opcode;
  assign n8   = it.immediate[7:0];
  assign hl   = {gp_r[clbe_pkg::IX_H], gp_r[clbe_pkg::IX_L]};
  assign p1   = pc_r + 16'd1;
  assign p2   = pc_r + 16'd2;
  assign p3   = pc_r + 16'd3;
  assign spm2 = sp_r - 16'd2;
  assign e16  = clbe_pkg::sext8(n8);
  assign zf   = flags_r[3];
  assign cf   = flags_r[0];
  assign dat  = it.read_data;
  assign b    = dat[7:0];
  assign hsum = {1'b0, sp_r[3:0]} + {1'b0, e16[3:0]};
  assign csum = {1'b0, sp_r[7:0]} + {1'b0, e16[7:0]};
  assign hl_sum = sp_r + e16;

  // Evaluate the branch condition from opcode bits 4:3
  always_comb begin
    case (op[4:3])
      2'd0:    cond = !zf;
      2'd1:    cond = zf;
      2'd2:    cond = !cf;
      default: cond = cf;
    endcase
  end

  // Execute the head word
  always_comb begin
    gp_nxt    = gp_r;
    flags_nxt = flags_r;
    sp_nxt    = sp_r;
    ime_nxt   = ime_r;
    halt_nxt  = halt_r;
    hbug_nxt  = hbug_r;
    stop_nxt  = stop_r;
    wop_nxt   = wop_r;
    wval_nxt  = 1'b0;
    phi       = {op[5:4], 1'b0};
    r         = '0;
    pc_nxt    = pc_r;
    if (it.operation == clbe_pkg::OPER_REPLY) begin
      // Finish the pending read, drop a stray reply
      if (wval_r) begin
        pc_nxt   = p1;
        r.cycles = 5'd8;
        phi      = {wop_r[5:4], 1'b0};
        if ((wop_r & 8'hC7) == 8'h46) begin
          gp_nxt[clbe_pkg::rix(wop_r[5:3])] = b;
        end else begin
          case (wop_r)
            8'h0A, 8'h1A, 8'hF2: gp_nxt[clbe_pkg::IX_A] = b;
            8'hFA: begin
              gp_nxt[clbe_pkg::IX_A] = b; pc_nxt = p3; r.cycles = 5'd16;
            end
            8'hF0: begin
              gp_nxt[clbe_pkg::IX_A] = b; pc_nxt = p2; r.cycles = 5'd12;
            end
            8'h2A: begin
              gp_nxt[clbe_pkg::IX_A] = b;
              {gp_nxt[clbe_pkg::IX_H], gp_nxt[clbe_pkg::IX_L]} = hl + 16'd1;
            end
            8'h3A: begin
              gp_nxt[clbe_pkg::IX_A] = b;
              {gp_nxt[clbe_pkg::IX_H], gp_nxt[clbe_pkg::IX_L]} = hl - 16'd1;
            end
            8'hC1, 8'hD1, 8'hE1: begin
              gp_nxt[phi]        = dat[15:8];
              gp_nxt[phi + 3'd1] = dat[7:0];
              sp_nxt = sp_r + 16'd2; r.cycles = 5'd12;
            end
            clbe_pkg::OP_POP_AF: begin
              gp_nxt[clbe_pkg::IX_A] = dat[15:8];
              flags_nxt = dat[7:4];
              sp_nxt = sp_r + 16'd2; r.cycles = 5'd12;
            end
            8'hD9: begin
              ime_nxt = 1'b1; pc_nxt = dat; sp_nxt = sp_r + 16'd2; r.cycles = 5'd16;
            end
            8'hC9: begin
              pc_nxt = dat; sp_nxt = sp_r + 16'd2; r.cycles = 5'd16;
            end
            8'hC0, 8'hC8, 8'hD0, 8'hD8: begin
              pc_nxt = dat; sp_nxt = sp_r + 16'd2; r.cycles = 5'd20;
            end
            default: begin
              pc_nxt = pc_r; r.cycles = 5'd0;
            end
          endcase
        end
      end
    end else begin
      pc_nxt = p1;
      unique case (it.iclass)
        clbe_pkg::CL_HALT: begin
          if (!ime_r && it.pending_irq != 5'd0) hbug_nxt = 1'b1;
          else halt_nxt = 1'b1;
          r.cycles = 5'd4;
        end
        clbe_pkg::CL_LDRR: begin
          if (op[5:3] == 3'd6) begin
            r.mem_addr = hl; r.mem_write = 1'b1;
            r.write_data = {8'd0, gp_r[clbe_pkg::rix(op[2:0])]};
            r.cycles = 5'd8;
          end else if (op[2:0] == 3'd6) begin
            r.mem_addr = hl; r.mem_read = 1'b1;
            wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
          end else begin
            gp_nxt[clbe_pkg::rix(op[5:3])] = gp_r[clbe_pkg::rix(op[2:0])];
            r.cycles = 5'd4;
          end
        end
        clbe_pkg::CL_LDRN: begin
          gp_nxt[clbe_pkg::rix(op[5:3])] = n8; pc_nxt = p2; r.cycles = 5'd8;
        end
        clbe_pkg::CL_PUSH: begin
          sp_nxt = spm2;
          r.mem_addr = spm2; r.mem_write = 1'b1; r.mem_wide = 1'b1;
          r.write_data = (op == clbe_pkg::OP_PUSH_AF) ?
                         {gp_r[clbe_pkg::IX_A], flags_r, 4'd0} :
                         {gp_r[phi], gp_r[phi + 3'd1]};
          r.cycles = 5'd16;
        end
        clbe_pkg::CL_POP: begin
          r.mem_addr = sp_r; r.mem_read = 1'b1; r.mem_wide = 1'b1;
          wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
        end
        clbe_pkg::CL_RST: begin
          sp_nxt = spm2;
          r.mem_addr = spm2; r.mem_write = 1'b1; r.mem_wide = 1'b1;
          r.write_data = p1; pc_nxt = {10'd0, op[5:3], 3'd0}; r.cycles = 5'd16;
        end
        default: begin
          unique case (op)
            8'h00: r.cycles = 5'd4;
            8'h01, 8'h11, 8'h21: begin
              gp_nxt[phi] = it.immediate[15:8];
              gp_nxt[phi + 3'd1] = it.immediate[7:0];
              pc_nxt = p3; r.cycles = 5'd12;
            end
            8'h31: begin
              sp_nxt = it.immediate; pc_nxt = p3; r.cycles = 5'd12;
            end
            8'h02, 8'h12: begin
              r.mem_addr = {gp_r[phi], gp_r[phi + 3'd1]}; r.mem_write = 1'b1;
              r.write_data = {8'd0, gp_r[clbe_pkg::IX_A]}; r.cycles = 5'd8;
            end
            8'h0A, 8'h1A: begin
              r.mem_addr = {gp_r[phi], gp_r[phi + 3'd1]}; r.mem_read = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            8'h08: begin
              r.mem_addr = it.immediate; r.mem_write = 1'b1; r.mem_wide = 1'b1;
              r.write_data = sp_r; pc_nxt = p3; r.cycles = 5'd20;
            end
            8'h10: begin
              stop_nxt = 1'b1; r.cycles = 5'd4;
            end
            8'h18: begin
              pc_nxt = p2 + e16; r.cycles = 5'd12;
            end
            8'h20, 8'h28, 8'h30, 8'h38: begin
              pc_nxt   = cond ? p2 + e16 : p2;
              r.cycles = cond ? 5'd12 : 5'd8;
            end
            8'h22, 8'h32: begin
              r.mem_addr = hl; r.mem_write = 1'b1;
              r.write_data = {8'd0, gp_r[clbe_pkg::IX_A]}; r.cycles = 5'd8;
              {gp_nxt[clbe_pkg::IX_H], gp_nxt[clbe_pkg::IX_L]} =
                op[4] ? hl - 16'd1 : hl + 16'd1;
            end
            8'h2A, 8'h3A: begin
              r.mem_addr = hl; r.mem_read = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            clbe_pkg::OP_LD_HL_N: begin
              r.mem_addr = hl; r.mem_write = 1'b1; r.write_data = {8'd0, n8};
              pc_nxt = p2; r.cycles = 5'd12;
            end
            8'hC0, 8'hC8, 8'hD0, 8'hD8: begin
              if (cond) begin
                r.mem_addr = sp_r; r.mem_read = 1'b1; r.mem_wide = 1'b1;
                wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
              end else begin
                r.cycles = 5'd8;
              end
            end
            8'hC9, 8'hD9: begin
              r.mem_addr = sp_r; r.mem_read = 1'b1; r.mem_wide = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            8'hC2, 8'hCA, 8'hD2, 8'hDA: begin
              pc_nxt   = cond ? it.immediate : p3;
              r.cycles = cond ? 5'd16 : 5'd12;
            end
            8'hC3: begin
              pc_nxt = it.immediate; r.cycles = 5'd16;
            end
            8'hC4, 8'hCC, 8'hD4, 8'hDC, 8'hCD: begin
              if (op == 8'hCD || cond) begin
                sp_nxt = spm2;
                r.mem_addr = spm2; r.mem_write = 1'b1; r.mem_wide = 1'b1;
                r.write_data = p3; pc_nxt = it.immediate; r.cycles = 5'd24;
              end else begin
                pc_nxt = p3; r.cycles = 5'd12;
              end
            end
            8'hE0: begin
              r.mem_addr = clbe_pkg::HIGH_PAGE | {8'd0, n8}; r.mem_write = 1'b1;
              r.write_data = {8'd0, gp_r[clbe_pkg::IX_A]}; pc_nxt = p2; r.cycles = 5'd12;
            end
            8'hE2: begin
              r.mem_addr = clbe_pkg::HIGH_PAGE | {8'd0, gp_r[clbe_pkg::IX_C]};
              r.mem_write = 1'b1;
              r.write_data = {8'd0, gp_r[clbe_pkg::IX_A]}; r.cycles = 5'd8;
            end
            8'hF0: begin
              r.mem_addr = clbe_pkg::HIGH_PAGE | {8'd0, n8}; r.mem_read = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            8'hF2: begin
              r.mem_addr = clbe_pkg::HIGH_PAGE | {8'd0, gp_r[clbe_pkg::IX_C]};
              r.mem_read = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            8'hEA: begin
              r.mem_addr = it.immediate; r.mem_write = 1'b1;
              r.write_data = {8'd0, gp_r[clbe_pkg::IX_A]}; pc_nxt = p3; r.cycles = 5'd16;
            end
            8'hFA: begin
              r.mem_addr = it.immediate; r.mem_read = 1'b1;
              wop_nxt = op; wval_nxt = 1'b1; pc_nxt = pc_r;
            end
            8'hE9: begin
              pc_nxt = hl; r.cycles = 5'd4;
            end
            8'hF9: begin
              sp_nxt = hl; r.cycles = 5'd8;
            end
            8'hF3: begin
              ime_nxt = 1'b0; r.cycles = 5'd4;
            end
            8'hFB: begin
              ime_nxt = 1'b1; r.cycles = 5'd4;
            end
            8'hF8: begin
              {gp_nxt[clbe_pkg::IX_H], gp_nxt[clbe_pkg::IX_L]} = hl_sum;
              flags_nxt = {2'b00, hsum[4], csum[8]};
              pc_nxt = p2; r.cycles = 5'd12;
            end
            default: begin
              // Unhandled opcode: stop and hold the pc
              stop_nxt = 1'b1; pc_nxt = pc_r;
            end
          endcase
        end
      endcase
    end
    r.next_pc   = pc_nxt;
    r.halted    = halt_nxt;
    r.stopped   = stop_nxt;
    r.halt_skip = hbug_nxt;
    r.ime       = ime_nxt;
  end

  // Commit architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) gp_r[i] <= 8'd0;
      flags_r <= 4'd0;
      sp_r    <= 16'd0;
      pc_r    <= 16'd0;
      ime_r   <= 1'b0;
      halt_r  <= 1'b0;
      hbug_r  <= 1'b0;
      stop_r  <= 1'b0;
      wop_r   <= 8'd0;
      wval_r  <= 1'b0;
    end else if (take) begin
      for (int i = 0; i < 7; i++) gp_r[i] <= gp_nxt[i];
      flags_r <= flags_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      ime_r   <= ime_nxt;
      halt_r  <= halt_nxt;
      hbug_r  <= hbug_nxt;
      stop_r  <= stop_nxt;
      wop_r   <= wop_nxt;
      wval_r  <= wval_nxt;
    end
  end

  // Result queue
  assign opop  = pop && (ocnt_r != 2'd0);
  assign empty = (ocnt_r == 2'd0);
  assign res   = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[owp_r] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (take) owp_r <= ~owp_r;
      if (opop) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, take} - {1'b0, opop};
    end
  end

endmodule

/* rtl/cpu_load_and_branch_execute_core.sv */
// Top level of the load, stack and branch execute core.
//
//   channel | direction | handshake   | words
//   in_     | input     | push / full | instruction or read reply
//   out_    | output    | empty / pop | one result per input word
//
// The execute stage handles one word at a time; a word may enter every cycle while full is low.
// A pushed word is registered in the input queue, and its result in the result queue, before it is visible.
// Both queues hold two words; full rises when the input queue is full.
// The execute stage stalls only when the result queue holds two words.
// Synchronous active-low reset clears all architectural state and both queues.
module cpu_load_and_branch_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_operation,
  input  logic [7:0]  in_opcode,
  input  logic [15:0] in_immediate,
  input  logic [15:0] in_read_data,
  input  logic [4:0]  in_pending_irq,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_mem_addr,
  output logic        out_mem_write,
  output logic        out_mem_read,
  output logic        out_mem_wide,
  output logic [15:0] out_write_data,
  output logic [15:0] out_next_pc,
  output logic [4:0]  out_cycles,
  output logic        out_halted,
  output logic        out_stopped,
  output logic        out_halt_skip,
  output logic        out_ime
);

  clbe_pkg::link_t head;
  clbe_pkg::res_t  res;
  logic            take;

  clbe_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_operation(in_operation), .in_opcode(in_opcode),
    .in_immediate(in_immediate), .in_read_data(in_read_data),
    .in_pending_irq(in_pending_irq), .head(head), .take(take)
  );

  clbe_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .take(take),
    .empty(empty), .pop(pop), .res(res)
  );

  assign out_mem_addr   = res.mem_addr;
  assign out_mem_write  = res.mem_write;
  assign out_mem_read   = res.mem_read;
  assign out_mem_wide   = res.mem_wide;
  assign out_write_data = res.write_data;
  assign out_next_pc    = res.next_pc;
  assign out_cycles     = res.cycles;
  assign out_halted     = res.halted;
  assign out_stopped    = res.stopped;
  assign out_halt_skip  = res.halt_skip;
  assign out_ime        = res.ime;

  // A result never both reads and writes
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_mem_write && out_mem_read))
    else $error("result both reads and writes");

  // Byte writes carry a clear upper byte
  a_byte_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_mem_wide) |-> (out_write_data[15:8] == 8'd0))
    else $error("byte write with upper data");

  // A read request costs nothing yet
  a_read_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_mem_read) |-> (out_cycles == 5'd0))
    else $error("read request with cycles");

  // Stop mark is sticky until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_stopped && pop) |=> (empty || out_stopped))
    else $error("stop mark cleared");

endmodule
